[rtl/core/uartrb_pkg.sv]
// shared types and constants for the uart register block
package uartrb_pkg;

  // request codes on the cmd field
  typedef enum logic [1:0] {
    CMD_READ  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_RX    = 2'd2
  } cmd_e;

  // register offsets
  localparam logic [2:0] REG_DATA = 3'd0;
  localparam logic [2:0] REG_IER  = 3'd1;
  localparam logic [2:0] REG_ISR  = 3'd2;
  localparam logic [2:0] REG_LC   = 3'd3;
  localparam logic [2:0] REG_MC   = 3'd4;
  localparam logic [2:0] REG_LS   = 3'd5;
  localparam logic [2:0] REG_MS   = 3'd6;

  localparam int unsigned NUM_REGS = 8;

  // register bits and values
  localparam int unsigned LC_DLAB_BIT = 7;
  localparam int unsigned IER_RX_BIT  = 0;
  localparam int unsigned IER_TX_BIT  = 1;
  localparam logic [7:0]  LS_THRE     = 8'h20;
  localparam logic [7:0]  LS_TEMT     = 8'h40;
  localparam logic [7:0]  LS_DR       = 8'h01;
  localparam logic [7:0]  IIR_RX      = 8'h04;
  localparam logic [7:0]  IIR_TX      = 8'h02;
  localparam logic [7:0]  IIR_NONE    = 8'h01;
  localparam logic [7:0]  RX_EMPTY    = 8'hff;

  // controller to datapath commands
  typedef struct packed {
    logic capture;
    logic commit;
  } dp_cmd_t;

endpackage

[rtl/core/uartrb_ram.sv]
// generic single-port-write, registered-read ram
module uartrb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/uartrb_ctrl.sv]
// request sequencer for the uart register block
module uartrb_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output uartrb_pkg::dp_cmd_t dp_cmd_o
);

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   capture;
  logic   commit;

  assign in_ready_o = (state_q == ST_IDLE);
  assign capture    = in_valid_i & in_ready_o;
  // execute once the output register is free or being emptied
  assign commit     = (state_q == ST_EXEC) & (~out_valid_q | out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (capture) begin
            state_q <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          if (commit) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
      if (commit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o      = out_valid_q;
  assign dp_cmd_o.capture = capture;
  assign dp_cmd_o.commit  = commit;

endmodule

[rtl/core/uartrb_dp.sv]
// register file, receive ring pointers and result registers
module uartrb_dp #(
  parameter int unsigned RX_DEPTH = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  uartrb_pkg::dp_cmd_t dp_cmd_i,
  input  logic [1:0]          cmd_i,
  input  logic [2:0]          offset_i,
  input  logic [7:0]          wdata_i,
  input  logic [7:0]          rx_byte_i,
  output logic [7:0]          rdata_o,
  output logic                tx_valid_o,
  output logic [7:0]          tx_byte_o,
  output logic                rx_dropped_o
);

  localparam int unsigned PTR_W = $clog2(RX_DEPTH);
  localparam logic [PTR_W-1:0] PtrLast = PTR_W'(RX_DEPTH - 1);

  // captured request
  logic [1:0] cmd_q;
  logic [2:0] off_q;
  logic [7:0] wdata_q;
  logic [7:0] rx_byte_q;

  // architectural state
  logic [7:0]       reg_file_q [uartrb_pkg::NUM_REGS];
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;

  // result registers
  logic [7:0] rdata_q, rdata_d;
  logic       tx_valid_q, tx_valid_d;
  logic [7:0] tx_byte_q, tx_byte_d;
  logic       rx_dropped_q, rx_dropped_d;

  logic             ram_we;
  logic [7:0]       ram_rdata;
  logic             has_data;
  logic [PTR_W-1:0] wr_next;
  logic [PTR_W-1:0] rd_next;
  logic             is_bus;
  logic             is_wr;
  logic [7:0]       reg_new;
  logic [7:0]       reg_final;

  // head entry is read every cycle so it is ready in the execute cycle
  uartrb_ram #(
    .WIDTH(8),
    .DEPTH(RX_DEPTH)
  ) u_rx_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(wr_ptr_q),
    .wdata_i(rx_byte_q),
    .raddr_i(rd_ptr_q),
    .rdata_o(ram_rdata)
  );

  assign has_data = (rd_ptr_q != wr_ptr_q);
  assign wr_next  = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
  assign rd_next  = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
  assign is_wr    = (cmd_q == uartrb_pkg::CMD_WRITE);
  assign is_bus   = (cmd_q == uartrb_pkg::CMD_READ) | is_wr;
  assign reg_new  = is_wr ? wdata_q : reg_file_q[off_q];

  always_comb begin
    ram_we       = 1'b0;
    rd_ptr_d     = rd_ptr_q;
    wr_ptr_d     = wr_ptr_q;
    reg_final    = reg_new;
    rdata_d      = 8'h00;
    tx_valid_d   = 1'b0;
    tx_byte_d    = 8'h00;
    rx_dropped_d = 1'b0;
    if (cmd_q == uartrb_pkg::CMD_RX) begin
      if (wr_next != rd_ptr_q) begin
        ram_we   = dp_cmd_i.commit;
        wr_ptr_d = wr_next;
      end else begin
        rx_dropped_d = 1'b1;
      end
    end else if (is_bus) begin
      case (off_q)
        uartrb_pkg::REG_DATA: begin
          if (is_wr) begin
            // line control is untouched by a data write
            if (!reg_file_q[uartrb_pkg::REG_LC][uartrb_pkg::LC_DLAB_BIT]) begin
              tx_valid_d = 1'b1;
              tx_byte_d  = wdata_q;
            end
          end else if (has_data) begin
            reg_final = ram_rdata;
            rd_ptr_d  = rd_next;
          end else begin
            reg_final = uartrb_pkg::RX_EMPTY;
          end
        end
        uartrb_pkg::REG_ISR: begin
          if (has_data && reg_file_q[uartrb_pkg::REG_IER][uartrb_pkg::IER_RX_BIT]) begin
            reg_final = uartrb_pkg::IIR_RX;
          end else if (reg_file_q[uartrb_pkg::REG_IER][uartrb_pkg::IER_TX_BIT]) begin
            reg_final = uartrb_pkg::IIR_TX;
          end else begin
            reg_final = uartrb_pkg::IIR_NONE;
          end
        end
        uartrb_pkg::REG_LS: begin
          reg_final = uartrb_pkg::LS_THRE | uartrb_pkg::LS_TEMT |
                      (has_data ? uartrb_pkg::LS_DR : 8'h00);
        end
        uartrb_pkg::REG_MC, uartrb_pkg::REG_MS: begin
          reg_final = 8'h00;
        end
        default: begin
          reg_final = reg_new;
        end
      endcase
      rdata_d = reg_final;
    end
  end

  always_ff @(posedge clk_i) begin
    if (dp_cmd_i.capture) begin
      cmd_q     <= cmd_i;
      off_q     <= offset_i;
      wdata_q   <= wdata_i;
      rx_byte_q <= rx_byte_i;
    end
    if (dp_cmd_i.commit) begin
      rdata_q      <= rdata_d;
      tx_valid_q   <= tx_valid_d;
      tx_byte_q    <= tx_byte_d;
      rx_dropped_q <= rx_dropped_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q <= '0;
      wr_ptr_q <= '0;
      for (int i = 0; i < uartrb_pkg::NUM_REGS; i++) begin
        reg_file_q[i] <= 8'h00;
      end
    end else if (dp_cmd_i.commit) begin
      rd_ptr_q <= rd_ptr_d;
      wr_ptr_q <= wr_ptr_d;
      if (is_bus) begin
        reg_file_q[off_q] <= reg_final;
      end
    end
  end

  assign rdata_o      = rdata_q;
  assign tx_valid_o   = tx_valid_q;
  assign tx_byte_o    = tx_byte_q;
  assign rx_dropped_o = rx_dropped_q;

endmodule

[rtl/core/uart_register_block_with_rx_fifo.sv]
// top level of the uart register block with receive ring buffer
// A 16550-style register file of eight byte registers behind a request channel,
// with a receive ring of RX_DEPTH entries that holds up to RX_DEPTH-1 bytes.
// Each request is a bus read (cmd 0), a bus write (cmd 1) or an arriving
// serial byte (cmd 2); each request yields exactly one response carrying the
// register value after a bus access (zero for a serial byte), a transmit
// strobe with its byte, and a drop flag for a receive into a full ring. A
// request has a capture cycle, in which the ring head is read from its ram
// (registered read), and an execute cycle, in which registers, pointers and
// the response register are updated. The next request is taken only once the
// previous one has executed, but while its response may still wait in the
// output register; the execute cycle holds only while that register is full.
// No clearing pass after reset: ring entries are only read after being written.
module uart_register_block_with_rx_fifo #(
  parameter int unsigned RX_DEPTH = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // request channel
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] cmd_i,
  input  logic [2:0] offset_i,
  input  logic [7:0] wdata_i,
  input  logic [7:0] rx_byte_i,
  // response channel
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] rdata_o,
  output logic       tx_valid_o,
  output logic [7:0] tx_byte_o,
  output logic       rx_dropped_o
);

  // capture / commit strobes from the sequencer
  uartrb_pkg::dp_cmd_t dp_cmd;

  // sequencer: idle/execute and the response valid flag
  uartrb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .dp_cmd_o   (dp_cmd)
  );

  // datapath: register file, ring pointers, ring ram and response registers
  uartrb_dp #(
    .RX_DEPTH(RX_DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .dp_cmd_i    (dp_cmd),
    .cmd_i       (cmd_i),
    .offset_i    (offset_i),
    .wdata_i     (wdata_i),
    .rx_byte_i   (rx_byte_i),
    .rdata_o     (rdata_o),
    .tx_valid_o  (tx_valid_o),
    .tx_byte_o   (tx_byte_o),
    .rx_dropped_o(rx_dropped_o)
  );

endmodule
